// ----- src/rgs_pkg.sv -----
// Shared types, codes and constants of the replay gap scheduler.
package rgs_pkg;

    // Default width of the millisecond gap before saturation
    localparam int GAP_BITS_DEF = 32;

    // Width of a positive microsecond difference between two timestamps
    localparam int RAW_W = 52;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
    localparam logic [9:0]  USEC_PER_MSEC = 10'd1000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ADJ_MODE   = 2'd0,
        REG_ADJ_VALUE  = 2'd1,
        REG_START_SEC  = 2'd2,
        REG_START_USEC = 2'd3
    } cfg_reg_t;

    // Gap adjustment modes; the two unused codes behave as none
    typedef enum logic [2:0] {
        ADJ_NONE  = 3'd0,
        ADJ_CONST = 3'd1,
        ADJ_ADD   = 3'd2,
        ADJ_SUB   = 3'd3,
        ADJ_MUL   = 3'd4,
        ADJ_DIV   = 3'd5
    } adj_mode_t;

    // Operations of the shared iterative arithmetic unit; OP_MSEC divides by 1000
    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_MUL  = 2'd1,
        OP_MSEC = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_FIRST,
        BK_PROD,
        BK_DIFF,
        BK_RAW,
        BK_ADJ,
        BK_LIM1,
        BK_LIM2,
        BK_CMP,
        BK_MULW,
        BK_QUOW,
        BK_SPLIT,
        BK_SUM,
        BK_NORM,
        BK_OUT
    } back_state_t;

    // One recorded timestamp
    typedef struct packed {
        logic [31:0] rec_sec;
        logic [19:0] rec_usec;
        logic        first_record;
    } rec_t;

    // One scheduled record
    typedef struct packed {
        logic [31:0] gap_msecs;
        logic [31:0] sched_sec;
        logic [19:0] sched_usec;
    } res_t;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [2:0]  adj_mode;
        logic [31:0] adj_value;
        logic [31:0] start_sec;
        logic [19:0] start_usec;
    } cfg_t;

    // Classified record handed from front to back
    typedef struct packed {
        logic        first;
        logic [32:0] dsec;
        logic [20:0] dusec;
    } job_t;

endpackage

// ----- src/replay_gap_scheduler_core.sv -----
// Replay gap scheduler: top level joining front end, job queue and back end.
//
// Usage: records (seconds, microseconds, first-record flag) enter through a
// queue-style port: a transfer happens when push is high and full is low.
// Scheduled results leave the same way: the oldest result sits on sched while
// empty is low and is taken when pop is high. Configuration is a plain write
// port (cfg_wen, cfg_addr, cfg_wdata); the user must write it only while the
// block is idle, which the block itself does not enforce.
// Records are worked on one at a time. A first record needs no division; any
// other needs a division by 1000 of its gap when that is positive, and one to
// split the adjusted gap into seconds and milliseconds. Add, multiply and
// divide also use the bit-serial divide and multiply and the division by 1000
// of the shared arithmetic unit. The front end and a two-entry job queue take
// new records while the back end works.
// Reset clears the configuration to its defaults and forgets the previous
// record, so the next record restarts the schedule. When the receiver stalls,
// the held result stays, the back end waits before its next result, and full
// rises once the job queue is also full.
module replay_gap_scheduler_core #(
    parameter int GAP_BITS = rgs_pkg::GAP_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    input  logic          push,
    output logic          full,
    input  rgs_pkg::rec_t rec,
    output logic          empty,
    input  logic          pop,
    output rgs_pkg::res_t sched
);

    rgs_pkg::cfg_t cfg;
    rgs_pkg::job_t in_job;
    rgs_pkg::job_t out_job;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    rgs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .push      (push),
        .rec       (rec),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (in_job)
    );

    rgs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (in_job),
        .full   (q_full),
        .pop    (q_pop),
        .rd_job (out_job),
        .empty  (q_empty)
    );

    rgs_back #(
        .GAP_BITS (GAP_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .job     (out_job),
        .empty   (empty),
        .pop     (pop),
        .sched   (sched)
    );

    assign full = q_full;

endmodule

// ----- src/rgs_arith.sv -----
// Shared iterative unit: bit-serial divider and multiplier, and a 16-bit-a-step divide by 1000.
module rgs_arith #(
    parameter int W = rgs_pkg::RAW_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rgs_pkg::arith_req_t req,
    input  logic [W-1:0]        opa,
    input  logic [31:0]         opb,
    output logic                done,
    output logic [W-1:0]        quo,
    output logic [31:0]         rem
);

    localparam int STEPS_MAX = (W > 32) ? W : 32;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    // Millisecond division: one 16-bit dividend digit per step
    localparam int KSTEPS = (W + 15) / 16;
    localparam int KW     = KSTEPS * 16;
    // ceil(2^30 / 125): exact quotient for every 23-bit numerator
    localparam logic [23:0] MSEC_RECIP = 24'd8589935;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    rgs_pkg::arith_op_t  op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        mcand_reg, mcand_next;
    logic [31:0]         rem_reg, rem_next;
    logic [31:0]         dvs_reg, dvs_next;
    logic [KW-1:0]       kx_reg, kx_next;

    logic [32:0]         shifted;
    logic [32:0]         trial;
    logic                ge;
    logic [W-1:0]        mul_sum;
    logic [25:0]         kv;
    logic [45:0]         kprod;
    logic [15:0]         kq;
    logic [9:0]          kr;

    // Partial remainder with the next dividend bit, and the trial subtraction
    assign shifted = {rem_reg, acc_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign mul_sum = (acc_reg << 1) + (dvs_reg[31] ? mcand_reg : '0);

    // Divide remainder and next digit by 1000: drop the factor 8, then multiply
    // by the reciprocal of 125
    assign kv    = {rem_reg[9:0], kx_reg[KW-1 -: 16]};
    assign kprod = 46'(kv[25:3]) * 46'(MSEC_RECIP);
    assign kq    = 16'(kprod >> 30);
    assign kr    = 10'(kv - 26'(kq) * 26'(rgs_pkg::USEC_PER_MSEC));

    // Step the selected operation
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        kx_next    = kx_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                dvs_next  = opb;
                rem_next  = '0;
                case (req.op)
                    rgs_pkg::OP_MUL:
                    begin
                        acc_next   = '0;
                        mcand_next = opa;
                        cnt_next   = CNT_W'(32);
                    end
                    rgs_pkg::OP_MSEC:
                    begin
                        kx_next  = KW'(opa);
                        cnt_next = CNT_W'(KSTEPS);
                    end
                    default:
                    begin
                        acc_next = opa;
                        cnt_next = CNT_W'(W);
                    end
                endcase
            end
        end
        else
        begin
            case (op_reg)
                rgs_pkg::OP_DIV:
                begin
                    rem_next = ge ? trial[31:0] : shifted[31:0];
                    acc_next = {acc_reg[W-2:0], ge};
                end
                rgs_pkg::OP_MUL:
                begin
                    acc_next = mul_sum;
                    dvs_next = dvs_reg << 1;
                end
                rgs_pkg::OP_MSEC:
                begin
                    rem_next = {22'd0, kr};
                    kx_next  = {kx_reg[KW-17:0], kq};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= rgs_pkg::OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        kx_reg    <= kx_next;
    end

    assign done = done_reg;
    assign quo  = (op_reg == rgs_pkg::OP_MSEC) ? kx_reg[W-1:0] : acc_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/rgs_back.sv -----
// Back end: works out gap, adjustment and running replay time for each queued record.
module rgs_back #(
    parameter int GAP_BITS = rgs_pkg::GAP_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rgs_pkg::cfg_t   cfg,
    input  logic            q_empty,
    output logic            q_pop,
    input  rgs_pkg::job_t   job,
    output logic            empty,
    input  logic            pop,
    output rgs_pkg::res_t   sched
);

    // Gap register is at least 32 bits so that a constant adjustment fits
    localparam int GXW    = (GAP_BITS > 32) ? GAP_BITS : 32;
    localparam int DW     = (GXW > rgs_pkg::RAW_W) ? GXW : rgs_pkg::RAW_W;
    localparam int DIFF_W = rgs_pkg::RAW_W + 2;

    localparam logic [64:0]       GMAX_WIDE = (65'd1 << GAP_BITS) - 65'd1;
    localparam logic [GXW-1:0]    GMAX      = GXW'(GMAX_WIDE);
    localparam logic [DW-1:0]     GMAX_DW   = DW'(GMAX_WIDE);
    localparam logic signed [DIFF_W-1:0] USEC_S = DIFF_W'(rgs_pkg::USEC_PER_SEC);

    rgs_pkg::back_state_t       state_reg, state_next;
    rgs_pkg::job_t              job_reg, job_next;
    logic [GXW-1:0]             g_reg, g_next;
    logic [GXW-1:0]             lim_reg, lim_next;
    logic signed [DIFF_W-1:0]   prod_reg, prod_next;
    logic [20:0]                usum_reg, usum_next;
    logic [31:0]                run_sec_reg, run_sec_next;
    logic [19:0]                run_usec_reg, run_usec_next;
    logic                       out_valid_reg, out_valid_next;
    rgs_pkg::res_t              out_reg, out_next;

    rgs_pkg::arith_req_t        arith_req;
    logic [DW-1:0]              arith_opa;
    logic [31:0]                arith_opb;
    logic                       arith_done;
    logic [DW-1:0]              arith_quo;
    logic [31:0]                arith_rem;

    logic signed [DIFF_W-1:0]   dsec_x;
    logic signed [DIFF_W-1:0]   dusec_x;
    logic signed [DIFF_W-1:0]   diff;
    logic                       diff_pos;
    logic [GXW-1:0]             adj_x;

    rgs_arith #(
        .W (DW)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .opa   (arith_opa),
        .opb   (arith_opb),
        .done  (arith_done),
        .quo   (arith_quo),
        .rem   (arith_rem)
    );

    // Signed time difference in microseconds
    assign dsec_x   = DIFF_W'($signed(job_reg.dsec));
    assign dusec_x  = DIFF_W'($signed(job_reg.dusec));
    assign diff     = prod_reg + dusec_x;
    assign diff_pos = !diff[DIFF_W-1] && (diff != '0);
    assign adj_x    = GXW'(cfg.adj_value);

    // Sequence one record through the shared unit
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        g_next         = g_reg;
        lim_next       = lim_reg;
        prod_next      = prod_reg;
        usum_next      = usum_reg;
        run_sec_next   = run_sec_reg;
        run_usec_next  = run_usec_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        arith_req.start = 1'b0;
        arith_req.op    = rgs_pkg::OP_DIV;
        arith_opa      = '0;
        arith_opb      = '0;

        // Drop the result once its transfer completes
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rgs_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = job;
                    state_next = job.first ? rgs_pkg::BK_FIRST : rgs_pkg::BK_PROD;
                end
            end
            rgs_pkg::BK_FIRST:
            begin
                // Restart at the start time, carrying excess microseconds
                if (cfg.start_usec >= rgs_pkg::USEC_PER_SEC)
                begin
                    run_sec_next  = cfg.start_sec + 32'd1;
                    run_usec_next = cfg.start_usec - rgs_pkg::USEC_PER_SEC;
                end
                else
                begin
                    run_sec_next  = cfg.start_sec;
                    run_usec_next = cfg.start_usec;
                end
                g_next     = '0;
                state_next = rgs_pkg::BK_OUT;
            end
            rgs_pkg::BK_PROD:
            begin
                prod_next  = dsec_x * USEC_S;
                state_next = rgs_pkg::BK_DIFF;
            end
            rgs_pkg::BK_DIFF:
            begin
                if (diff_pos)
                begin
                    arith_req.start = 1'b1;
                    arith_req.op    = rgs_pkg::OP_MSEC;
                    arith_opa  = DW'(diff[rgs_pkg::RAW_W-1:0]);
                    state_next = rgs_pkg::BK_RAW;
                end
                else
                begin
                    g_next     = '0;
                    state_next = rgs_pkg::BK_ADJ;
                end
            end
            rgs_pkg::BK_RAW:
            begin
                // Saturate the raw gap at the gap width
                if (arith_done)
                begin
                    g_next     = (arith_quo > GMAX_DW) ? GMAX : arith_quo[GXW-1:0];
                    state_next = rgs_pkg::BK_ADJ;
                end
            end
            rgs_pkg::BK_ADJ:
            begin
                state_next = rgs_pkg::BK_SPLIT;
                case (cfg.adj_mode)
                    rgs_pkg::ADJ_CONST:
                    begin
                        g_next = adj_x;
                    end
                    rgs_pkg::ADJ_ADD:
                    begin
                        if (adj_x > GMAX)
                        begin
                            lim_next   = '0;
                            state_next = rgs_pkg::BK_CMP;
                        end
                        else
                        begin
                            arith_req.start = 1'b1;
                            arith_req.op    = rgs_pkg::OP_MSEC;
                            arith_opa  = DW'(GMAX - adj_x);
                            state_next = rgs_pkg::BK_LIM2;
                        end
                    end
                    rgs_pkg::ADJ_SUB:
                    begin
                        g_next = (g_reg < adj_x) ? '0 : g_reg - adj_x;
                    end
                    rgs_pkg::ADJ_MUL:
                    begin
                        if (cfg.adj_value == '0)
                        begin
                            g_next = '0;
                        end
                        else
                        begin
                            arith_req.start = 1'b1;
                            arith_opa  = GMAX_DW;
                            arith_opb  = cfg.adj_value;
                            state_next = rgs_pkg::BK_LIM1;
                        end
                    end
                    rgs_pkg::ADJ_DIV:
                    begin
                        if (cfg.adj_value == '0)
                        begin
                            g_next = GMAX;
                        end
                        else
                        begin
                            arith_req.start = 1'b1;
                            arith_opa  = DW'(g_reg);
                            arith_opb  = cfg.adj_value;
                            state_next = rgs_pkg::BK_QUOW;
                        end
                    end
                    default:
                    begin
                        g_next = g_reg;
                    end
                endcase
            end
            rgs_pkg::BK_LIM1:
            begin
                // Scale the multiply limit down to milliseconds
                if (arith_done)
                begin
                    arith_req.start = 1'b1;
                    arith_req.op    = rgs_pkg::OP_MSEC;
                    arith_opa  = arith_quo;
                    state_next = rgs_pkg::BK_LIM2;
                end
            end
            rgs_pkg::BK_LIM2:
            begin
                if (arith_done)
                begin
                    lim_next   = arith_quo[GXW-1:0];
                    state_next = rgs_pkg::BK_CMP;
                end
            end
            rgs_pkg::BK_CMP:
            begin
                if (g_reg > lim_reg)
                begin
                    g_next     = lim_reg;
                    state_next = rgs_pkg::BK_SPLIT;
                end
                else if (cfg.adj_mode == rgs_pkg::ADJ_MUL)
                begin
                    arith_req.start = 1'b1;
                    arith_req.op    = rgs_pkg::OP_MUL;
                    arith_opa  = DW'(g_reg);
                    arith_opb  = cfg.adj_value;
                    state_next = rgs_pkg::BK_MULW;
                end
                else
                begin
                    g_next     = g_reg + adj_x;
                    state_next = rgs_pkg::BK_SPLIT;
                end
            end
            rgs_pkg::BK_MULW, rgs_pkg::BK_QUOW:
            begin
                if (arith_done)
                begin
                    g_next     = arith_quo[GXW-1:0];
                    state_next = rgs_pkg::BK_SPLIT;
                end
            end
            rgs_pkg::BK_SPLIT:
            begin
                // Split the gap into seconds and leftover milliseconds
                arith_req.start = 1'b1;
                arith_req.op    = rgs_pkg::OP_MSEC;
                arith_opa  = DW'(g_reg);
                state_next = rgs_pkg::BK_SUM;
            end
            rgs_pkg::BK_SUM:
            begin
                if (arith_done)
                begin
                    run_sec_next = run_sec_reg + arith_quo[31:0];
                    usum_next    = {1'b0, run_usec_reg}
                                 + 21'(20'(arith_rem[9:0]) * 20'(rgs_pkg::USEC_PER_MSEC));
                    state_next   = rgs_pkg::BK_NORM;
                end
            end
            rgs_pkg::BK_NORM:
            begin
                // Normalise microseconds with a carry into the seconds
                if (usum_reg >= 21'(rgs_pkg::USEC_PER_SEC))
                begin
                    run_usec_next = 20'(usum_reg - 21'(rgs_pkg::USEC_PER_SEC));
                    run_sec_next  = run_sec_reg + 32'd1;
                end
                else
                begin
                    run_usec_next = usum_reg[19:0];
                end
                state_next = rgs_pkg::BK_OUT;
            end
            rgs_pkg::BK_OUT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || pop)
                begin
                    out_valid_next       = 1'b1;
                    out_next.gap_msecs  = g_reg[31:0];
                    out_next.sched_sec  = run_sec_reg;
                    out_next.sched_usec = run_usec_reg;
                    state_next          = rgs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rgs_pkg::BK_IDLE;
            end
        endcase
    end

    // Hold control state and the running replay time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgs_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            run_sec_reg   <= '0;
            run_usec_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            run_sec_reg   <= run_sec_next;
            run_usec_reg  <= run_usec_next;
        end
    end

    // Hold the working values of the current record
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        g_reg    <= g_next;
        lim_reg  <= lim_next;
        prod_reg <= prod_next;
        usum_reg <= usum_next;
        out_reg  <= out_next;
    end

    assign empty = !out_valid_reg;
    assign sched = out_reg;

endmodule

// ----- src/rgs_queue.sv -----
// Short job queue between the front and back ends.
module rgs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rgs_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output rgs_pkg::job_t rd_job,
    output logic          empty
);

    localparam int DEPTH = rgs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgs_pkg::job_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ----- src/rgs_front.sv -----
// Front end: configuration registers, record intake and classification.
module rgs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    output rgs_pkg::cfg_t cfg,
    input  logic          push,
    input  rgs_pkg::rec_t rec,
    input  logic          q_full,
    output logic          q_push,
    output rgs_pkg::job_t q_job
);

    logic [2:0]  adj_mode_reg;
    logic [31:0] adj_value_reg;
    logic [31:0] start_sec_reg;
    logic [19:0] start_usec_reg;
    logic [31:0] last_sec_reg;
    logic [19:0] last_usec_reg;
    logic        have_prev_reg;

    assign q_push = push && !q_full;

    // Classify the record: restart, or difference to the previous timestamp
    always_comb
    begin
        q_job.first = rec.first_record || !have_prev_reg;
        q_job.dsec  = {1'b0, rec.rec_sec} - {1'b0, last_sec_reg};
        q_job.dusec = {1'b0, rec.rec_usec} - {1'b0, last_usec_reg};
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_mode_reg   <= rgs_pkg::ADJ_NONE;
            adj_value_reg  <= 32'd1;
            start_sec_reg  <= '0;
            start_usec_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                rgs_pkg::REG_ADJ_MODE:   adj_mode_reg   <= cfg_wdata[2:0];
                rgs_pkg::REG_ADJ_VALUE:  adj_value_reg  <= cfg_wdata;
                rgs_pkg::REG_START_SEC:  start_sec_reg  <= cfg_wdata;
                rgs_pkg::REG_START_USEC: start_usec_reg <= cfg_wdata[19:0];
                default:                 adj_mode_reg   <= adj_mode_reg;
            endcase
        end
    end

    // Remember the last accepted timestamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sec_reg  <= '0;
            last_usec_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (q_push)
        begin
            last_sec_reg  <= rec.rec_sec;
            last_usec_reg <= rec.rec_usec;
            have_prev_reg <= 1'b1;
        end
    end

    assign cfg.adj_mode   = adj_mode_reg;
    assign cfg.adj_value  = adj_value_reg;
    assign cfg.start_sec  = start_sec_reg;
    assign cfg.start_usec = start_usec_reg;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the replay gap scheduler core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgs_pkg::*;

    localparam int GAP_BITS        = GAP_BITS_DEF;
    localparam int IDLE_PCT        = 19;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int RANDOM_PHASES   = 30;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int PRINT_CAP       = 100;
    localparam logic [63:0] USEC_SEC  = 64'd1000000;
    localparam logic [63:0] USEC_MSEC = 64'd1000;
    localparam logic [63:0] GAP_MAX   = ((64'd1 << (GAP_BITS - 1)) << 1) - 64'd1;

    // Tracks the replay schedule and holds the results still to come
    class replay_schedule_tracker;
        logic [2:0]  adj_mode   = ADJ_NONE;
        logic [31:0] adj_value  = 32'd1;
        logic [31:0] start_sec  = '0;
        logic [19:0] start_usec = '0;
        logic [31:0] last_sec   = '0;
        logic [19:0] last_usec  = '0;
        logic [31:0] run_sec    = '0;
        logic [19:0] run_usec   = '0;
        bit          have_prev  = 1'b0;
        res_t        pending_sched[$];
        int          mismatches = 0;

        function void set_reg(cfg_reg_t idx, logic [31:0] val);
            case (idx)
                REG_ADJ_MODE:   adj_mode   = val[2:0];
                REG_ADJ_VALUE:  adj_value  = val;
                REG_START_SEC:  start_sec  = val;
                REG_START_USEC: start_usec = val[19:0];
                default: ;
            endcase
        endfunction

        // Whole milliseconds since the previous record, floored and saturated
        function logic [63:0] recorded_gap(rec_t r);
            logic [63:0] now_us;
            logic [63:0] prev_us;
            logic [63:0] g;
            now_us  = {32'h0, r.rec_sec} * USEC_SEC + 64'(r.rec_usec);
            prev_us = {32'h0, last_sec} * USEC_SEC + 64'(last_usec);
            if (now_us <= prev_us)
                return 64'd0;
            g = (now_us - prev_us) / USEC_MSEC;
            return (g > GAP_MAX) ? GAP_MAX : g;
        endfunction

        function logic [63:0] adjusted_gap(logic [63:0] g);
            logic [63:0] a;
            logic [63:0] lim;
            a = {32'h0, adj_value};
            case (adj_mode)
                ADJ_CONST: return a;
                ADJ_ADD:
                begin
                    lim = (a > GAP_MAX) ? 64'd0 : (GAP_MAX - a) / USEC_MSEC;
                    return (g > lim) ? lim : g + a;
                end
                ADJ_SUB: return (g < a) ? 64'd0 : g - a;
                ADJ_MUL:
                begin
                    if (a == 64'd0)
                        return 64'd0;
                    lim = (GAP_MAX / a) / USEC_MSEC;
                    return (g > lim) ? lim : g * a;
                end
                ADJ_DIV: return (a == 64'd0) ? GAP_MAX : g / a;
                default: return g;
            endcase
        endfunction

        // Advance the schedule for an accepted record and hold its result
        function void note_record(rec_t r);
            logic [63:0] g;
            logic [63:0] u;
            res_t        want;
            g = 64'd0;
            if (r.first_record || !have_prev)
            begin
                run_sec  = start_sec + 32'(64'(start_usec) / USEC_SEC);
                run_usec = 20'(64'(start_usec) % USEC_SEC);
            end
            else
            begin
                g = adjusted_gap(recorded_gap(r));
                u = 64'(run_usec) + (g % USEC_MSEC) * USEC_MSEC;
                run_sec = run_sec + 32'(g / USEC_MSEC);
                if (u >= USEC_SEC)
                begin
                    u = u - USEC_SEC;
                    run_sec = run_sec + 32'd1;
                end
                run_usec = 20'(u);
            end
            last_sec  = r.rec_sec;
            last_usec = r.rec_usec;
            have_prev = 1'b1;
            want.gap_msecs  = g[31:0];
            want.sched_sec  = run_sec;
            want.sched_usec = run_usec;
            pending_sched.push_back(want);
        endfunction

        function int pending();
            return pending_sched.size();
        endfunction

        // Print one line per mismatch up to a cap, count them all
        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_sched(res_t got);
            res_t want;
            if (pending_sched.size() == 0)
            begin
                report_mismatch("unexpected result gap", got.gap_msecs, '0);
                return;
            end
            want = pending_sched.pop_front();
            if (got.gap_msecs !== want.gap_msecs)
                report_mismatch("gap_msecs", got.gap_msecs, want.gap_msecs);
            if (got.sched_sec !== want.sched_sec)
                report_mismatch("sched_sec", got.sched_sec, want.sched_sec);
            if (got.sched_usec !== want.sched_usec)
                report_mismatch("sched_usec", 32'(got.sched_usec), 32'(want.sched_usec));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        push;
    logic        full;
    rec_t        rec;
    logic        empty;
    logic        pop;
    res_t        sched;

    replay_schedule_tracker sb;
    bit   no_idle = 1'b0;
    rec_t last_sent = '0;
    int   quiet_cycles = 0;

    replay_gap_scheduler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .rec       (rec),
        .empty     (empty),
        .pop       (pop),
        .sched     (sched)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // End the run when nothing has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wen || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL replay_gap_scheduler_core");
            $finish;
        end
    end

    // Drain results with random stalls
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= !(!no_idle && $urandom_range(99) < IDLE_PCT);
            @(posedge clk);
            if (pop && !empty)
                sb.check_sched(sched);
        end
    end

    // Offer one record, idling first at random; return at the next falling edge
    task send_record(rec_t r);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        rec  <= r;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        sb.note_record(r);
        last_sent = r;
        @(negedge clk);
    endtask

    // Drop push, wait for every result, then let the back end settle
    task drain_and_settle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        sb.set_reg(idx, val);
    endtask

    task program_settings(logic [2:0] mode, logic [31:0] value, logic [31:0] ssec,
                          logic [19:0] susec);
        write_reg(REG_ADJ_MODE, 32'(mode));
        write_reg(REG_ADJ_VALUE, value);
        write_reg(REG_START_SEC, ssec);
        write_reg(REG_START_USEC, 32'(susec));
        cfg_wen <= 1'b0;
    endtask

    function automatic rec_t make_record();
        rec_t        r;
        int unsigned pick;
        logic [63:0] t;
        pick = $urandom_range(99);
        r.first_record = 1'b0;
        if (pick < 5)
        begin
            // start a fresh trace anywhere in the seconds range
            r.first_record = 1'b1;
            r.rec_sec  = $urandom;
            r.rec_usec = 20'($urandom_range(999999));
        end
        else if (pick < 10)
        begin
            // noise, including unnormalised microseconds
            r.first_record = 1'($urandom);
            r.rec_sec  = $urandom;
            r.rec_usec = 20'($urandom);
        end
        else if (pick < 14)
        begin
            // step back or repeat the timestamp
            r.rec_sec  = last_sent.rec_sec - 32'($urandom_range(2));
            r.rec_usec = last_sent.rec_usec;
        end
        else if (pick < 18)
        begin
            // jump far enough to saturate the gap at times
            r.rec_sec  = last_sent.rec_sec + $urandom;
            r.rec_usec = 20'($urandom_range(999999));
        end
        else
        begin
            // ordinary forward step of a trace
            t = {32'h0, last_sent.rec_sec} * USEC_SEC + 64'(last_sent.rec_usec);
            t = t + ((pick < 50) ? 64'($urandom_range(5000)) : 64'($urandom_range(3000000)));
            r.rec_sec  = 32'(t / USEC_SEC);
            r.rec_usec = 20'(t % USEC_SEC);
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_adj_value();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'd999;
            4: return 32'd1000;
            5: return 32'hFFFF_FFFF;
            6: return $urandom;
            default: return 32'($urandom_range(50));
        endcase
    endfunction

    function automatic logic [31:0] pick_start_sec();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFF - 32'($urandom_range(100));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [19:0] pick_start_usec();
        case ($urandom_range(3))
            0: return 20'd0;
            1: return 20'd999999;
            2: return 20'($urandom_range(20'hFFFFF, 1000000));
            default: return 20'($urandom_range(999999));
        endcase
    endfunction

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = REG_ADJ_MODE;
        cfg_wdata = '0;
        push      = 1'b0;
        rec       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: first record without the flag, gap edges and saturation
        send_record('{rec_sec: 32'd0, rec_usec: 20'd0, first_record: 1'b0});
        send_record('{rec_sec: 32'd0, rec_usec: 20'd999999, first_record: 1'b0});
        send_record('{rec_sec: 32'd0, rec_usec: 20'd999999, first_record: 1'b0});
        send_record('{rec_sec: 32'd0, rec_usec: 20'd500, first_record: 1'b0});
        send_record('{rec_sec: 32'hFFFF_FFFF, rec_usec: 20'hFFFFF, first_record: 1'b0});
        send_record('{rec_sec: 32'hFFFF_FFFF, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd0, rec_usec: 20'd2999, first_record: 1'b0});
        send_record('{rec_sec: 32'd0, rec_usec: 20'hFFFFF, first_record: 1'b0});
        drain_and_settle();

        // Each mode at its awkward operands, start time carrying and wrapping
        program_settings(ADJ_CONST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
        send_record('{rec_sec: 32'd10, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd11, rec_usec: 20'd0, first_record: 1'b0});
        drain_and_settle();
        program_settings(ADJ_ADD, 32'hFFFF_FFFF, 32'd0, 20'd999999);
        send_record('{rec_sec: 32'd20, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd21, rec_usec: 20'd1, first_record: 1'b0});
        drain_and_settle();
        program_settings(ADJ_SUB, 32'd1000, 32'd5, 20'd0);
        send_record('{rec_sec: 32'd30, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd30, rec_usec: 20'd999999, first_record: 1'b0});
        send_record('{rec_sec: 32'd33, rec_usec: 20'd0, first_record: 1'b0});
        drain_and_settle();
        program_settings(ADJ_MUL, 32'd0, 32'd7, 20'd1000000);
        send_record('{rec_sec: 32'd40, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd41, rec_usec: 20'd0, first_record: 1'b0});
        drain_and_settle();
        program_settings(ADJ_MUL, 32'd1000, 32'd7, 20'd0);
        send_record('{rec_sec: 32'd50, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'hFFFF_0000, rec_usec: 20'd0, first_record: 1'b0});
        drain_and_settle();
        program_settings(ADJ_DIV, 32'd0, 32'd1, 20'd1);
        send_record('{rec_sec: 32'd60, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd61, rec_usec: 20'd0, first_record: 1'b0});
        drain_and_settle();
        program_settings(3'd7, 32'd3, 32'd2, 20'd2);
        send_record('{rec_sec: 32'd70, rec_usec: 20'd0, first_record: 1'b1});
        send_record('{rec_sec: 32'd72, rec_usec: 20'd500000, first_record: 1'b0});
        drain_and_settle();

        // Random traces, one setting per phase; a run of phases without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            no_idle = (phase >= 10 && phase < 15);
            program_settings(3'(phase % 8), pick_adj_value(), pick_start_sec(),
                             pick_start_usec());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_record(make_record());
            drain_and_settle();
        end

        if (sb.mismatches == 0)
            $display("PASS replay_gap_scheduler_core");
        else
            $display("FAIL replay_gap_scheduler_core");
        $finish;
    end

endmodule

// ----- files.f -----
src/rgs_pkg.sv
src/rgs_arith.sv
src/rgs_back.sv
src/rgs_queue.sv
src/rgs_front.sv
src/replay_gap_scheduler_core.sv
dv/tb_top.sv
